[hdl/assert_macros.svh]
// Assertion macros used by the RTL of the execute core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds in the same cycle as its antecedent, clocked on clk.
`define M68K_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check that holds in the cycle after its antecedent, clocked on clk.
`define M68K_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/m68k_pkg.sv]
// Types, opcode constants and condition evaluation for the execute core.
package m68k_pkg;

    localparam int FLAG_C = 0;
    localparam int FLAG_V = 1;
    localparam int FLAG_Z = 2;
    localparam int FLAG_N = 3;
    localparam int FLAG_X = 4;

    localparam logic [15:0] OPC_NOP       = 16'h4E71;
    localparam logic [15:0] OPC_RTS       = 16'h4E75;
    localparam logic [15:0] MASK_MOVEQ    = 16'hF100;
    localparam logic [15:0] MATCH_MOVEQ   = 16'h7000;
    localparam logic [15:0] MASK_ADDQ     = 16'hF038;
    localparam logic [15:0] MATCH_ADDQ    = 16'h5000;
    localparam logic [15:0] MASK_DBCC     = 16'hF0F8;
    localparam logic [15:0] MATCH_DBCC    = 16'h50C8;
    localparam logic [15:0] MASK_BCC      = 16'hF000;
    localparam logic [15:0] MATCH_BCC     = 16'h6000;
    localparam logic [31:0] MASK_HIGH_WORD = 32'hFFFF0000;

    localparam logic [1:0] SIZE_BYTE    = 2'd0;
    localparam logic [1:0] SIZE_WORD    = 2'd1;
    localparam logic [1:0] SIZE_INVALID = 2'd3;

    localparam logic [3:0] COND_T   = 4'd0;
    localparam logic [3:0] CC_FALSE = 4'd1;
    localparam logic [3:0] COND_HI  = 4'd2;
    localparam logic [3:0] COND_LS  = 4'd3;
    localparam logic [3:0] COND_CC  = 4'd4;
    localparam logic [3:0] COND_CS  = 4'd5;
    localparam logic [3:0] COND_NE  = 4'd6;
    localparam logic [3:0] COND_EQ  = 4'd7;
    localparam logic [3:0] COND_VC  = 4'd8;
    localparam logic [3:0] COND_VS  = 4'd9;
    localparam logic [3:0] COND_PL  = 4'd10;
    localparam logic [3:0] COND_MI  = 4'd11;
    localparam logic [3:0] COND_GE  = 4'd12;
    localparam logic [3:0] COND_LT  = 4'd13;
    localparam logic [3:0] COND_GT  = 4'd14;

    localparam logic [4:0] CYC_SHORT  = 5'd4;
    localparam logic [4:0] CYC_BRANCH = 5'd10;
    localparam logic [4:0] CYC_DB_END = 5'd14;
    localparam logic [4:0] CYC_RTS    = 5'd16;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_RTS,
        OP_MOVEQ,
        OP_ADDQ,
        OP_DBCC,
        OP_BCC,
        OP_UNIMPL
    } op_class_t;

    function automatic logic cond_true(input logic [4:0] f, input logic [3:0] cc);
        logic c;
        logic v;
        logic z;
        logic n;
        logic res;
        c = f[FLAG_C];
        v = f[FLAG_V];
        z = f[FLAG_Z];
        n = f[FLAG_N];
        case (cc)
            COND_T:   res = 1'b1;
            CC_FALSE: res = 1'b0;
            COND_HI:  res = !c && !z;
            COND_LS:  res = c || z;
            COND_CC:  res = !c;
            COND_CS:  res = c;
            COND_NE:  res = !z;
            COND_EQ:  res = z;
            COND_VC:  res = !v;
            COND_VS:  res = v;
            COND_PL:  res = !n;
            COND_MI:  res = n;
            COND_GE:  res = n == v;
            COND_LT:  res = n != v;
            COND_GT:  res = !z && (n == v);
            default:  res = z || (n != v);
        endcase
        return res;
    endfunction

endpackage

[hdl/m68k_subset_execute_core_unit.sv]
// Top level of the execute core for a small 68000 instruction subset.
//
// Usage: each input beat on in_valid/in_stall carries the two code words at
// the current program counter, opcode_word and extension_word, as fetched by
// the caller. The core executes one instruction per beat and returns one
// result beat on out_valid/out_stall with the next program counter, flags,
// cycle charge, running totals and the data register written, if any.
// The code length register is written through cfg_we/cfg_data; the caller
// must write it only while idle, which the core itself does not enforce.
// A new instruction is taken every cycle while the receiver does not stall;
// the input register and the result register frame a single pass through
// decode, the ADDQ/SUBQ adder, the DBcc decrement and branch target adders.
// Reset clears the data registers, program counter, flags, halt mark and all
// totals. When the receiver stalls, the result is held and one further beat
// waits in the input register; only then is in_stall raised.
module m68k_subset_execute_core_unit
    import m68k_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [24:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] opcode_word,
    input  logic [15:0] extension_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] next_pc,
    output logic [4:0]  status_flags,
    output logic [4:0]  cycles_taken,
    output logic [31:0] cycles_total,
    output logic        is_halted,
    output logic        unimplemented,
    output logic [31:0] unimplemented_count,
    output logic        reg_written,
    output logic [2:0]  reg_index,
    output logic [31:0] reg_value
);

    `include "assert_macros.svh"

    logic [24:0] code_len_reg;
    logic        in_vld_reg, in_vld_next;
    logic [15:0] op_reg, ext_reg;
    logic        out_vld_reg, out_vld_next;

    logic [31:0] dregs_reg [8];
    logic [31:0] pc_reg, pc_next;
    logic [4:0]  flags_reg, flags_next;
    logic        halt_reg, halt_next;
    logic [31:0] cyc_sum_reg, cyc_sum_next;
    logic [31:0] unk_sum_reg, unk_sum_next;

    logic [4:0]  cycles_next;
    logic        unimpl_next;
    logic        wr_next;
    logic [2:0]  ridx_next;
    logic [31:0] rval_next;

    logic        in_take;
    logic        exec_go;

    logic [32:0] len_ext;
    logic [32:0] pc_ext;
    logic [31:0] base;
    logic [32:0] base_ext;
    logic [15:0] op;
    logic [15:0] ext;
    op_class_t   op_class;

    logic [31:0] src_reg;
    logic [1:0]  size;
    logic [3:0]  quick;
    logic [31:0] width_mask;
    logic [31:0] a_m;
    logic [32:0] r_full;
    logic [31:0] r_m;
    logic        carry;
    logic        a_s;
    logic        r_s;
    logic        ovf;
    logic [31:0] moveq_val;
    logic [15:0] db_low;
    logic [31:0] disp16;
    logic [31:0] disp8;

    assign exec_go  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !exec_go;
    assign in_take  = in_valid && !in_stall;

    assign in_vld_next  = in_take ? 1'b1 : (exec_go ? 1'b0 : in_vld_reg);
    assign out_vld_next = exec_go ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);

    // Code bytes at or beyond the code length read as zero.
    assign len_ext  = {8'd0, code_len_reg};
    assign pc_ext   = {1'b0, pc_reg};
    assign base     = pc_reg + 32'd2;
    assign base_ext = {1'b0, base};
    assign op[15:8] = (pc_ext < len_ext) ? op_reg[15:8] : 8'd0;
    assign op[7:0]  = ((pc_ext + 33'd1) < len_ext) ? op_reg[7:0] : 8'd0;
    assign ext[15:8] = (base_ext < len_ext) ? ext_reg[15:8] : 8'd0;
    assign ext[7:0]  = ((base_ext + 33'd1) < len_ext) ? ext_reg[7:0] : 8'd0;

    always_comb
    begin
        if (op == OPC_NOP)
        begin
            op_class = OP_NOP;
        end
        else if (op == OPC_RTS)
        begin
            op_class = OP_RTS;
        end
        else if ((op & MASK_MOVEQ) == MATCH_MOVEQ)
        begin
            op_class = OP_MOVEQ;
        end
        else if ((op & MASK_ADDQ) == MATCH_ADDQ && op[7:6] != SIZE_INVALID)
        begin
            op_class = OP_ADDQ;
        end
        else if ((op & MASK_DBCC) == MATCH_DBCC)
        begin
            op_class = OP_DBCC;
        end
        else if ((op & MASK_BCC) == MATCH_BCC)
        begin
            op_class = OP_BCC;
        end
        else
        begin
            op_class = OP_UNIMPL;
        end
    end

    // Quick add and subtract work at the operand size and keep the upper bits.
    always_comb
    begin
        src_reg = dregs_reg[op[2:0]];
        size    = op[7:6];
        quick   = (op[11:9] == 3'd0) ? 4'd8 : {1'b0, op[11:9]};
        case (size)
            SIZE_BYTE: width_mask = 32'h0000_00FF;
            SIZE_WORD: width_mask = 32'h0000_FFFF;
            default:   width_mask = 32'hFFFF_FFFF;
        endcase
        a_m = src_reg & width_mask;
        if (op[8])
        begin
            r_full = {1'b0, a_m} - {29'd0, quick};
        end
        else
        begin
            r_full = {1'b0, a_m} + {29'd0, quick};
        end
        r_m = r_full[31:0] & width_mask;
        case (size)
            SIZE_BYTE:
            begin
                a_s   = a_m[7];
                r_s   = r_m[7];
                carry = op[8] ? r_full[32] : r_full[8];
            end
            SIZE_WORD:
            begin
                a_s   = a_m[15];
                r_s   = r_m[15];
                carry = op[8] ? r_full[32] : r_full[16];
            end
            default:
            begin
                a_s   = a_m[31];
                r_s   = r_m[31];
                carry = r_full[32];
            end
        endcase
        ovf = op[8] ? (a_s && !r_s) : (!a_s && r_s);
    end

    assign moveq_val = {{24{op[7]}}, op[7:0]};
    assign disp8     = {{24{op[7]}}, op[7:0]};
    assign disp16    = {{16{ext[15]}}, ext};
    assign db_low    = src_reg[15:0] - 16'd1;

    always_comb
    begin
        pc_next      = pc_reg;
        flags_next   = flags_reg;
        halt_next    = halt_reg;
        cycles_next  = 5'd0;
        unimpl_next  = 1'b0;
        unk_sum_next = unk_sum_reg;
        wr_next      = 1'b0;
        ridx_next    = 3'd0;
        rval_next    = 32'd0;
        if (!halt_reg)
        begin
            pc_next     = base;
            cycles_next = CYC_SHORT;
            case (op_class)
                OP_NOP:
                begin
                end
                OP_RTS:
                begin
                    halt_next   = 1'b1;
                    cycles_next = CYC_RTS;
                end
                OP_MOVEQ:
                begin
                    ridx_next          = op[11:9];
                    rval_next          = moveq_val;
                    wr_next            = 1'b1;
                    flags_next         = 5'd0;
                    flags_next[FLAG_X] = flags_reg[FLAG_X];
                    flags_next[FLAG_Z] = (moveq_val == 32'd0);
                    flags_next[FLAG_N] = moveq_val[31];
                end
                OP_ADDQ:
                begin
                    ridx_next          = op[2:0];
                    rval_next          = (src_reg & ~width_mask) | r_m;
                    wr_next            = 1'b1;
                    flags_next[FLAG_C] = carry;
                    flags_next[FLAG_X] = carry;
                    flags_next[FLAG_V] = ovf;
                    flags_next[FLAG_Z] = (r_m == 32'd0);
                    flags_next[FLAG_N] = r_s;
                end
                OP_DBCC:
                begin
                    pc_next     = base + 32'd2;
                    cycles_next = CYC_BRANCH;
                    if (!cond_true(flags_reg, op[11:8]))
                    begin
                        ridx_next = op[2:0];
                        rval_next = (src_reg & MASK_HIGH_WORD) | {16'd0, db_low};
                        wr_next   = 1'b1;
                        if (db_low != 16'hFFFF)
                        begin
                            pc_next = base + disp16;
                        end
                        else
                        begin
                            cycles_next = CYC_DB_END;
                        end
                    end
                end
                OP_BCC:
                begin
                    cycles_next = CYC_BRANCH;
                    if (op[11:8] == CC_FALSE || cond_true(flags_reg, op[11:8]))
                    begin
                        pc_next = base + disp8;
                    end
                end
                default:
                begin
                    unimpl_next  = 1'b1;
                    unk_sum_next = unk_sum_reg + 32'd1;
                end
            endcase
        end
        cyc_sum_next = cyc_sum_reg + {27'd0, cycles_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_len_reg <= 25'd0;
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            pc_reg       <= 32'd0;
            flags_reg    <= 5'd0;
            halt_reg     <= 1'b0;
            cyc_sum_reg  <= 32'd0;
            unk_sum_reg  <= 32'd0;
            for (int i = 0; i < 8; i++)
            begin
                dregs_reg[i] <= 32'd0;
            end
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                code_len_reg <= cfg_data;
            end
            if (exec_go)
            begin
                pc_reg      <= pc_next;
                flags_reg   <= flags_next;
                halt_reg    <= halt_next;
                cyc_sum_reg <= cyc_sum_next;
                unk_sum_reg <= unk_sum_next;
                if (wr_next)
                begin
                    dregs_reg[ridx_next] <= rval_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= opcode_word;
            ext_reg <= extension_word;
        end
        if (exec_go)
        begin
            next_pc             <= pc_next;
            status_flags        <= flags_next;
            cycles_taken        <= cycles_next;
            cycles_total        <= cyc_sum_next;
            is_halted           <= halt_next;
            unimplemented       <= unimpl_next;
            unimplemented_count <= unk_sum_next;
            reg_written         <= wr_next;
            reg_index           <= ridx_next;
            reg_value           <= rval_next;
        end
    end

    assign out_valid = out_vld_reg;

    `M68K_ASSERT_NEXT(a_halt_sticky, halt_reg, halt_reg)
    `M68K_ASSERT_NEXT(a_halt_pc_hold, halt_reg && exec_go, $stable(pc_reg))
    `M68K_ASSERT_NEXT(a_unk_count, exec_go && unimpl_next, unk_sum_reg == $past(unk_sum_reg) + 1)
    `M68K_ASSERT_NEXT(a_exec_result, exec_go, out_vld_reg)

endmodule

[sim/testbench.sv]
// Self-checking testbench for the execute core: table-driven beats, then random ones.
module testbench;
    import m68k_pkg::*;

    localparam logic [24:0] CODE_LEN_MAX = 25'h1000000;
    localparam int          STUCK_LIMIT  = 2000;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          DRAIN_PAD    = 4;
    localparam int          NDIR         = 23;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [4:0]  flags;
        logic [4:0]  cycles;
        logic [31:0] total;
        logic        halted;
        logic        unimpl;
        logic [31:0] unimpl_count;
        logic        wr;
        logic [2:0]  ridx;
        logic [31:0] rval;
    } exec_res_t;

    typedef struct packed {
        logic        set_len;
        logic [24:0] len;
        logic [15:0] op;
        logic [15:0] ext;
        logic        typed;
        exec_res_t   res;
    } dir_row_t;

    localparam exec_res_t NO_RES = '0;

    localparam dir_row_t DIR_TAB [NDIR] = '{
        '{1'b0, 25'd0, 16'h4E75, 16'hFFFF, 1'b1,
          '{32'd2, 5'd0, 5'd4, 32'd4, 1'b0, 1'b1, 32'd1, 1'b0, 3'd0, 32'd0}},
        '{1'b0, 25'd0, 16'hFFFF, 16'h0000, 1'b1,
          '{32'd4, 5'd0, 5'd4, 32'd8, 1'b0, 1'b1, 32'd2, 1'b0, 3'd0, 32'd0}},
        '{1'b1, CODE_LEN_MAX, 16'h60F8, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h4E71, 16'hFFFF, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h7000, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h7E80, 16'hFFFF, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h727F, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h74FF, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h5282, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h5001, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h5340, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h5107, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h50C0, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h5048, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h51CB, 16'hFFFC, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h51CB, 16'h0010, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h50CB, 16'h1234, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h6000, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h6104, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h6700, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h4E71, 16'h0000, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h0000, 16'hFFFF, 1'b0, NO_RES},
        '{1'b0, 25'd0, 16'h56CC, 16'h8000, 1'b0, NO_RES}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [24:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] opcode_word = '0;
    logic [15:0] extension_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] next_pc;
    logic [4:0]  status_flags;
    logic [4:0]  cycles_taken;
    logic [31:0] cycles_total;
    logic        is_halted;
    logic        unimplemented;
    logic [31:0] unimplemented_count;
    logic        reg_written;
    logic [2:0]  reg_index;
    logic [31:0] reg_value;

    logic [31:0] emu_d [8];
    logic [31:0] emu_pc;
    logic [4:0]  emu_ccr;
    logic        emu_halted;
    logic [31:0] emu_cyc_sum;
    logic [31:0] emu_unimpl_sum;
    logic [24:0] emu_code_len;

    exec_res_t pending_results [$];

    int  class_hits [7];
    int  halted_beats;
    int  cfg_writes;
    int  beats_sent;
    int  results_seen;
    int  error_count;
    int  stuck_cycles;
    int  holds_done;
    bit  calm;
    bit  hold_pending;

    m68k_subset_execute_core_unit uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .opcode_word         (opcode_word),
        .extension_word      (extension_word),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .next_pc             (next_pc),
        .status_flags        (status_flags),
        .cycles_taken        (cycles_taken),
        .cycles_total        (cycles_total),
        .is_halted           (is_halted),
        .unimplemented       (unimplemented),
        .unimplemented_count (unimplemented_count),
        .reg_written         (reg_written),
        .reg_index           (reg_index),
        .reg_value           (reg_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bytes at or beyond the code length read as zero; the address is not allowed to wrap.
    function automatic logic [15:0] fetch_word(input logic [15:0] w, input logic [31:0] addr);
        logic [32:0] a;
        logic [32:0] lim;
        logic [15:0] v;
        a = {1'b0, addr};
        lim = {8'b0, emu_code_len};
        v = w;
        if (a >= lim)
        begin
            v[15:8] = 8'h00;
        end
        if (a + 33'd1 >= lim)
        begin
            v[7:0] = 8'h00;
        end
        return v;
    endfunction

    function automatic logic branch_taken(input logic [4:0] f, input logic [3:0] cc);
        logic c;
        logic v;
        logic z;
        logic n;
        logic t;
        c = f[FLAG_C];
        v = f[FLAG_V];
        z = f[FLAG_Z];
        n = f[FLAG_N];
        case (cc)
            COND_T:   t = 1'b1;
            CC_FALSE: t = 1'b0;
            COND_HI:  t = !c && !z;
            COND_LS:  t = c || z;
            COND_CC:  t = !c;
            COND_CS:  t = c;
            COND_NE:  t = !z;
            COND_EQ:  t = z;
            COND_VC:  t = !v;
            COND_VS:  t = v;
            COND_PL:  t = !n;
            COND_MI:  t = n;
            COND_GE:  t = n == v;
            COND_LT:  t = n != v;
            COND_GT:  t = !z && (n == v);
            default:  t = z || (n != v);
        endcase
        return t;
    endfunction

    task automatic emulate_instr(input logic [15:0] raw_op, input logic [15:0] raw_ext,
                                 output exec_res_t r);
        logic [15:0] op;
        logic [15:0] ext;
        logic [31:0] base;
        logic [31:0] v;
        logic [31:0] a;
        logic [31:0] q;
        logic [31:0] mask;
        logic [31:0] sign;
        logic [32:0] wide;
        logic [15:0] lo;
        logic [2:0]  rn;
        logic [1:0]  sz;
        logic        cy;
        logic        ov;
        logic        keep_x;
        op_class_t   cls;
        r = '0;
        cls = OP_UNIMPL;
        if (!emu_halted)
        begin
            op = fetch_word(raw_op, emu_pc);
            base = emu_pc + 32'd2;
            emu_pc = base;
            r.cycles = CYC_SHORT;
            sz = op[7:6];
            if (op == OPC_NOP)
            begin
                cls = OP_NOP;
            end
            else if (op == OPC_RTS)
            begin
                cls = OP_RTS;
                emu_halted = 1'b1;
                r.cycles = CYC_RTS;
            end
            else if ((op & MASK_MOVEQ) == MATCH_MOVEQ)
            begin
                cls = OP_MOVEQ;
                v = {{24{op[7]}}, op[7:0]};
                rn = op[11:9];
                emu_d[rn] = v;
                keep_x = emu_ccr[FLAG_X];
                emu_ccr = '0;
                emu_ccr[FLAG_X] = keep_x;
                emu_ccr[FLAG_Z] = (v == 32'd0);
                emu_ccr[FLAG_N] = v[31];
                r.wr = 1'b1;
                r.ridx = rn;
                r.rval = v;
            end
            else if ((op & MASK_ADDQ) == MATCH_ADDQ && sz != SIZE_INVALID)
            begin
                cls = OP_ADDQ;
                q = (op[11:9] == 3'd0) ? 32'd8 : {29'd0, op[11:9]};
                mask = (sz == SIZE_BYTE) ? 32'hFF : (sz == SIZE_WORD) ? 32'hFFFF : 32'hFFFFFFFF;
                sign = (mask >> 1) + 32'd1;
                rn = op[2:0];
                a = emu_d[rn] & mask;
                if (op[8])
                begin
                    v = (a - q) & mask;
                    cy = a < q;
                    ov = |((a ^ q) & (a ^ v) & sign);
                end
                else
                begin
                    wide = {1'b0, a} + {1'b0, q};
                    v = wide[31:0] & mask;
                    cy = wide > {1'b0, mask};
                    ov = |(~(a ^ q) & (a ^ v) & sign);
                end
                emu_ccr = '0;
                emu_ccr[FLAG_C] = cy;
                emu_ccr[FLAG_X] = cy;
                emu_ccr[FLAG_V] = ov;
                emu_ccr[FLAG_Z] = (v == 32'd0);
                emu_ccr[FLAG_N] = |(v & sign);
                emu_d[rn] = (emu_d[rn] & ~mask) | v;
                r.wr = 1'b1;
                r.ridx = rn;
                r.rval = emu_d[rn];
            end
            else if ((op & MASK_DBCC) == MATCH_DBCC)
            begin
                cls = OP_DBCC;
                ext = fetch_word(raw_ext, base);
                emu_pc = base + 32'd2;
                r.cycles = CYC_BRANCH;
                if (!branch_taken(emu_ccr, op[11:8]))
                begin
                    rn = op[2:0];
                    lo = emu_d[rn][15:0] - 16'd1;
                    emu_d[rn] = (emu_d[rn] & MASK_HIGH_WORD) | {16'd0, lo};
                    r.wr = 1'b1;
                    r.ridx = rn;
                    r.rval = emu_d[rn];
                    if (lo != 16'hFFFF)
                    begin
                        emu_pc = base + {{16{ext[15]}}, ext};
                    end
                    else
                    begin
                        r.cycles = CYC_DB_END;
                    end
                end
            end
            else if ((op & MASK_BCC) == MATCH_BCC)
            begin
                cls = OP_BCC;
                r.cycles = CYC_BRANCH;
                if (op[11:8] == CC_FALSE || branch_taken(emu_ccr, op[11:8]))
                begin
                    emu_pc = base + {{24{op[7]}}, op[7:0]};
                end
            end
            else
            begin
                r.unimpl = 1'b1;
                emu_unimpl_sum = emu_unimpl_sum + 32'd1;
            end
            emu_cyc_sum = emu_cyc_sum + {27'd0, r.cycles};
            class_hits[int'(cls)]++;
        end
        else
        begin
            halted_beats++;
        end
        r.next_pc = emu_pc;
        r.flags = emu_ccr;
        r.total = emu_cyc_sum;
        r.halted = emu_halted;
        r.unimpl_count = emu_unimpl_sum;
    endtask

    // Turns a branch displacement round when its target would leave the code area.
    function automatic logic [15:0] keep_in_code(input logic [15:0] d, input logic is_word);
        longint tgt;
        longint lim;
        if (is_word)
        begin
            tgt = longint'(emu_pc) + 2 + longint'($signed(d));
        end
        else
        begin
            tgt = longint'(emu_pc) + 2 + longint'($signed(d[7:0]));
        end
        lim = longint'(emu_code_len) - 8;
        if (tgt < 0 || tgt > lim)
        begin
            d = is_word ? ~d : {d[15:8], ~d[7:0]};
        end
        return d;
    endfunction

    task automatic pick_instr(output logic [15:0] op, output logic [15:0] ext);
        int          kind;
        logic [2:0]  rn;
        logic [2:0]  q;
        logic [3:0]  cc;
        logic [7:0]  d8;
        logic [1:0]  sz;
        logic        sub;
        kind = $urandom_range(0, 99);
        rn = 3'($urandom);
        q = 3'($urandom);
        cc = 4'($urandom);
        d8 = 8'($urandom);
        sub = 1'($urandom);
        sz = 2'($urandom_range(0, 2));
        ext = 16'($urandom);
        if (kind < 15)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                d8 = 8'd0;
            end
            op = MATCH_MOVEQ | {4'b0, rn, 1'b0, d8};
        end
        else if (kind < 40)
        begin
            op = MATCH_ADDQ | {4'b0, q, sub, sz, 3'b000, rn};
        end
        else if (kind < 55)
        begin
            op = MATCH_DBCC | {4'b0, cc, 5'b0, rn};
        end
        else if (kind < 75)
        begin
            op = MATCH_BCC | {4'b0, cc, d8};
        end
        else if (kind < 80)
        begin
            op = OPC_NOP;
        end
        else
        begin
            op = 16'($urandom);
        end
        if (kind < 80)
        begin
            if ((op & MASK_DBCC) == MATCH_DBCC)
            begin
                ext = keep_in_code(ext, 1'b1);
            end
            else if ((op & MASK_BCC) == MATCH_BCC)
            begin
                op = keep_in_code(op, 1'b0);
            end
        end
        // A halt is kept for the end of the run, since nothing clears it.
        if (fetch_word(op, emu_pc) == OPC_RTS)
        begin
            op = OPC_NOP;
        end
    endtask

    task automatic drive_instr(input logic [15:0] op, input logic [15:0] ext,
                               input logic typed, input exec_res_t given);
        exec_res_t predicted;
        emulate_instr(op, ext, predicted);
        if (!calm && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(0, 99) < 27);
        end
        in_valid <= 1'b1;
        opcode_word <= op;
        extension_word <= ext;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_results.push_back(typed ? given : predicted);
        beats_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_code_len(input logic [24:0] len);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= len;
        @(posedge clk);
        cfg_we <= 1'b0;
        emu_code_len = len;
        cfg_writes++;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("%0t: result beat %0d, %s: got %h, expected %h",
                 $time, results_seen, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        exec_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("beat with nothing outstanding", next_pc, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("next_pc", next_pc, want.next_pc);
                check_field("status_flags", status_flags, want.flags);
                check_field("cycles_taken", cycles_taken, want.cycles);
                check_field("cycles_total", cycles_total, want.total);
                check_field("is_halted", is_halted, want.halted);
                check_field("unimplemented", unimplemented, want.unimpl);
                check_field("unimplemented_count", unimplemented_count, want.unimpl_count);
                check_field("reg_written", reg_written, want.wr);
                check_field("reg_index", reg_index, want.ridx);
                check_field("reg_value", reg_value, want.rval);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                stuck_cycles <= 0;
            end
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("Timed out after %0d cycles without a beat.", stuck_cycles);
                $display("m68k_subset_execute_core_unit: mismatch");
                $finish;
            end
            else
            begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // The receiver holds off once for a long stretch so that the core fills and stalls its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            out_stall <= !calm && ($urandom_range(0, 99) < 27);
        end
    end

    initial
    begin
        logic [15:0] op;
        logic [15:0] ext;
        logic [24:0] len;
        longint      near_len;
        int          n;
        for (int i = 0; i < 8; i++)
        begin
            emu_d[i] = '0;
        end
        emu_pc = '0;
        emu_ccr = '0;
        emu_halted = 1'b0;
        emu_cyc_sum = '0;
        emu_unimpl_sum = '0;
        emu_code_len = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NDIR; i++)
        begin
            if (DIR_TAB[i].set_len)
            begin
                set_code_len(DIR_TAB[i].len);
            end
            drive_instr(DIR_TAB[i].op, DIR_TAB[i].ext, DIR_TAB[i].typed, DIR_TAB[i].res);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: len = CODE_LEN_MAX;
                1:
                begin
                    near_len = longint'(emu_pc) + longint'($urandom_range(0, 7));
                    len = (near_len > longint'(CODE_LEN_MAX)) ? CODE_LEN_MAX : 25'(near_len);
                end
                2:
                begin
                    near_len = longint'(emu_pc) + 512;
                    if (near_len >= longint'(CODE_LEN_MAX))
                    begin
                        len = CODE_LEN_MAX;
                    end
                    else
                    begin
                        len = 25'($urandom_range(32'(near_len), 32'(CODE_LEN_MAX)));
                    end
                end
                default: len = 25'h0FFFFFF;
            endcase
            set_code_len(len);
            calm = (ph == 4);
            n = (ph % 2 == 1) ? 30 : 290;
            for (int k = 0; k < n; k++)
            begin
                if (ph == 0 && k == 100)
                begin
                    hold_pending = 1'b1;
                end
                pick_instr(op, ext);
                drive_instr(op, ext, 1'b0, NO_RES);
            end
        end
        calm = 1'b0;

        // Once halted, every further beat must leave the state alone.
        set_code_len(CODE_LEN_MAX);
        drive_instr(OPC_RTS, 16'($urandom), 1'b0, NO_RES);
        repeat (6)
        begin
            op = 16'($urandom);
            ext = 16'($urandom);
            drive_instr(op, ext, 1'b0, NO_RES);
        end
        wait_drained();

        $display("Covered %0d beats under %0d code length settings and %0d long holds: %0d NOP,",
                 beats_sent, cfg_writes, holds_done, class_hits[int'(OP_NOP)]);
        $display("%0d MOVEQ, %0d ADDQ/SUBQ, %0d DBcc, %0d Bcc, %0d unrecognised, %0d RTS, %0d halted.",
                 class_hits[int'(OP_MOVEQ)], class_hits[int'(OP_ADDQ)],
                 class_hits[int'(OP_DBCC)], class_hits[int'(OP_BCC)],
                 class_hits[int'(OP_UNIMPL)], class_hits[int'(OP_RTS)], halted_beats);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("m68k_subset_execute_core_unit: match");
        end
        else
        begin
            $display("m68k_subset_execute_core_unit: mismatch");
        end
        $finish;
    end

endmodule
